@@ rtl/core/apu_pkg.sv @@
// Shared constants for the optimizer update pipeline: codes, register map and reset values.
package apu_pkg;

  localparam int          COEF_BITS = 24;
  localparam logic [24:0] COEF_ONE  = 25'h100_0000;

  localparam logic [1:0] OPT_ADAM    = 2'd0;
  localparam logic [1:0] OPT_ADAGRAD = 2'd1;

  localparam logic [1:0] MODE_USER = 2'd0;
  localparam logic [1:0] MODE_ITEM = 2'd1;

  localparam logic [2:0] REG_OPT  = 3'd0;
  localparam logic [2:0] REG_NORM = 3'd1;
  localparam logic [2:0] REG_LR   = 3'd2;
  localparam logic [2:0] REG_B1   = 3'd3;
  localparam logic [2:0] REG_B2   = 3'd4;
  localparam logic [2:0] REG_RU   = 3'd5;
  localparam logic [2:0] REG_RI   = 3'd6;
  localparam logic [2:0] REG_RB   = 3'd7;

  localparam logic [23:0] LR_RESET = 24'd16777;
  localparam logic [23:0] B1_RESET = 24'd15099494;
  localparam logic [23:0] B2_RESET = 24'd16760439;

endpackage

@@ rtl/core/adam_adagrad_param_update.sv @@
// Top level: pipelined Adam / Adagrad parameter update with APB register port; other codes pass inputs through.
// Path: normalization divider, regularizer and moment stages, beta power chain, the two bias-correction
//   dividers in parallel, root, step divider, learning-rate product and output register.
// Throughput: one item per cycle; busy is high only during reset, out_valid strobes one cycle.
// Reset: synchronous active-low rst_n drops every item in flight and restores register defaults.
module adam_adagrad_param_update #(
  parameter int FRAC_BITS = 24,
  parameter int STEP_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic signed [31:0] in_param_value,
  input  logic signed [31:0] in_gradient,
  input  logic signed [31:0] in_momentum_in,
  input  logic [31:0]        in_velocity_in,
  input  logic [15:0]        in_sample_count,
  input  logic [15:0]        in_step_index,
  output logic               out_valid,
  output logic signed [31:0] out_param_out,
  output logic signed [31:0] out_momentum_out,
  output logic [31:0]        out_velocity_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int TB      = ((STEP_BITS < 16) ? STEP_BITS : 16) + 1;
  localparam int XW      = ((32 + FRAC_BITS + 1) / 2) * 2;
  localparam int RW      = XW / 2;
  localparam int DIV_LAT = 33;
  localparam int LAT     = 3 * DIV_LAT + (RW + 1) + TB + 10;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] p;
    logic signed [31:0] g;
    logic signed [31:0] m_in;
    logic [31:0]        v_in;
    logic signed [31:0] m;
    logic [31:0]        v;
    logic [31:0]        g2;
    logic [TB-1:0]      t;
    logic [24:0]        r1;
    logic [24:0]        r2;
    logic [23:0]        bs1;
    logic [23:0]        bs2;
    logic signed [31:0] n;
    logic [31:0]        y;
    logic signed [31:0] step;
  } item_t;

  localparam int IW = $bits(item_t);

  function automatic logic signed [31:0] sat_s32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return $signed(v[31:0]);
  endfunction

  function automatic logic [31:0] sat_u32(input logic [63:0] v);
    return (|v[63:32]) ? 32'hffff_ffff : v[31:0];
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic signed [31:0] sm_sat(input logic neg, input logic [31:0] q,
                                                input logic ovf);
    if (!neg) begin
      return (ovf || q[31]) ? 32'sh7fff_ffff : $signed(q);
    end
    return (ovf || q > 32'h8000_0000) ? 32'sh8000_0000 : $signed(-q);
  endfunction

  // configuration registers
  logic [1:0]  opt_sel_r;
  logic        norm_en_r;
  logic [23:0] learning_rate_r, beta_first_r, beta_second_r;
  logic [23:0] reg_user_r, reg_item_r, reg_bias_r;
  logic        cfg_wr;
  logic        is_adam, is_ada;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign is_adam = (opt_sel_r == apu_pkg::OPT_ADAM);
  assign is_ada  = (opt_sel_r == apu_pkg::OPT_ADAGRAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opt_sel_r       <= apu_pkg::OPT_ADAM;
      norm_en_r       <= 1'b0;
      learning_rate_r <= apu_pkg::LR_RESET;
      beta_first_r    <= apu_pkg::B1_RESET;
      beta_second_r   <= apu_pkg::B2_RESET;
      reg_user_r      <= '0;
      reg_item_r      <= '0;
      reg_bias_r      <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        apu_pkg::REG_OPT:  opt_sel_r       <= pwdata[1:0];
        apu_pkg::REG_NORM: norm_en_r       <= pwdata[0];
        apu_pkg::REG_LR:   learning_rate_r <= pwdata[23:0];
        apu_pkg::REG_B1:   beta_first_r    <= pwdata[23:0];
        apu_pkg::REG_B2:   beta_second_r   <= pwdata[23:0];
        apu_pkg::REG_RU:   reg_user_r      <= pwdata[23:0];
        apu_pkg::REG_RI:   reg_item_r      <= pwdata[23:0];
        apu_pkg::REG_RB:   reg_bias_r      <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      apu_pkg::REG_OPT:  prdata = 32'(opt_sel_r);
      apu_pkg::REG_NORM: prdata = 32'(norm_en_r);
      apu_pkg::REG_LR:   prdata = 32'(learning_rate_r);
      apu_pkg::REG_B1:   prdata = 32'(beta_first_r);
      apu_pkg::REG_B2:   prdata = 32'(beta_second_r);
      apu_pkg::REG_RU:   prdata = 32'(reg_user_r);
      apu_pkg::REG_RI:   prdata = 32'(reg_item_r);
      apu_pkg::REG_RB:   prdata = 32'(reg_bias_r);
      default:           prdata = '0;
    endcase
  end

  assign busy = !rst_n;

  // entry and gradient normalization
  item_t       in_item;
  logic [15:0] nd_den;
  logic        acc;

  assign acc    = start && !busy;
  assign nd_den = (norm_en_r && in_sample_count != 16'd0) ? in_sample_count : 16'd1;

  always_comb begin
    in_item      = '0;
    in_item.mode = in_mode;
    in_item.p    = in_param_value;
    in_item.g    = in_gradient;
    in_item.m_in = in_momentum_in;
    in_item.v_in = in_velocity_in;
    in_item.m    = in_momentum_in;
    in_item.v    = in_velocity_in;
    in_item.t    = TB'(in_step_index[TB-2:0]) + TB'(1);
  end

  logic        nd_vld, nd_ovf;
  logic [31:0] nd_q;
  item_t       nd_item;

  apu_div #(.NW(33), .DW(16), .QW(32), .SW(IW)) u_ndiv (
    .clk(clk), .rst_n(rst_n), .in_valid(acc),
    .in_num({1'b0, abs32(in_gradient)}), .in_den(nd_den), .in_side(in_item),
    .out_valid(nd_vld), .out_quo(nd_q), .out_ovf(nd_ovf), .out_side(nd_item)
  );

  // regularizer product
  logic               r_vld_r;
  item_t              r_item_r, r_item_nxt;
  logic signed [56:0] r_prod_r, r_prod_nxt;
  logic [23:0]        r_coef;

  always_comb begin
    r_item_nxt   = nd_item;
    r_item_nxt.g = nd_item.g[31] ? $signed(-nd_q) : $signed(nd_q);
    case (nd_item.mode)
      apu_pkg::MODE_USER: r_coef = reg_user_r;
      apu_pkg::MODE_ITEM: r_coef = reg_item_r;
      default:            r_coef = reg_bias_r;
    endcase
    r_prod_nxt = $signed({1'b0, r_coef}) * nd_item.p;
  end

  // regularized gradient
  logic               s_vld_r;
  item_t              s_item_r, s_item_nxt;
  logic signed [33:0] s_rq;
  logic signed [34:0] s_diff;

  always_comb begin
    s_item_nxt   = r_item_r;
    s_rq         = 34'(r_prod_r >>> 23);
    s_diff       = 35'(r_item_r.g) - 35'(s_rq);
    s_item_nxt.g = sat_s32(64'(s_diff));
  end

  // squared gradient and first-moment products
  logic               m_vld_r;
  item_t              m_item_r;
  logic [63:0]        m_gg_r, m_gg_nxt;
  logic signed [56:0] m_pm1_r, m_pm1_nxt;
  logic signed [57:0] m_pm2_r, m_pm2_nxt;
  logic [31:0]        m_mag;
  logic [24:0]        b1c, b2c;

  assign b1c = apu_pkg::COEF_ONE - {1'b0, beta_first_r};
  assign b2c = apu_pkg::COEF_ONE - {1'b0, beta_second_r};

  always_comb begin
    m_mag     = abs32(s_item_r.g);
    m_gg_nxt  = m_mag * m_mag;
    m_pm1_nxt = $signed({1'b0, beta_first_r}) * s_item_r.m_in;
    m_pm2_nxt = $signed({1'b0, b1c}) * s_item_r.g;
  end

  // first moment, squared gradient
  logic               n_vld_r;
  item_t              n_item_r, n_item_nxt;
  logic signed [58:0] n_sum;
  logic [63:0]        n_gs;

  always_comb begin
    n_item_nxt    = m_item_r;
    n_sum         = 59'(m_pm1_r) + 59'(m_pm2_r);
    n_item_nxt.m  = sat_s32(64'(n_sum >>> 24));
    n_gs          = m_gg_r >> FRAC_BITS;
    n_item_nxt.g2 = sat_u32(n_gs);
  end

  // second-moment products, Adagrad accumulation
  logic        v_vld_r;
  item_t       v_item_r, v_item_nxt;
  logic [55:0] v_pv1_r, v_pv1_nxt;
  logic [56:0] v_pv2_r, v_pv2_nxt;

  always_comb begin
    v_item_nxt   = n_item_r;
    v_pv1_nxt    = beta_second_r * n_item_r.v_in;
    v_pv2_nxt    = b2c * n_item_r.g2;
    v_item_nxt.v = sat_u32(64'(n_item_r.v_in) + 64'(n_item_r.g2));
  end

  // Adam second moment, seed the power chain
  logic        w_vld_r;
  item_t       w_item_r, w_item_nxt;
  logic [57:0] w_sum;

  always_comb begin
    w_item_nxt = v_item_r;
    w_sum      = 58'(v_pv1_r) + 58'(v_pv2_r);
    if (is_adam) begin
      w_item_nxt.v = sat_u32(64'(w_sum >> 24));
    end
    w_item_nxt.r1  = apu_pkg::COEF_ONE;
    w_item_nxt.r2  = apu_pkg::COEF_ONE;
    w_item_nxt.bs1 = beta_first_r;
    w_item_nxt.bs2 = beta_second_r;
  end

  // beta^t, one exponent bit per stage
  logic [TB-1:0] pw_vld_r;
  item_t         pw_item_r  [TB];
  item_t         pw_item_nxt[TB];
  item_t         pw_src     [TB];
  logic [48:0]   pw_p1[TB];
  logic [48:0]   pw_p2[TB];
  logic [47:0]   pw_s1[TB];
  logic [47:0]   pw_s2[TB];

  always_comb begin
    pw_src[0] = w_item_r;
    for (int k = 1; k < TB; k++) begin
      pw_src[k] = pw_item_r[k-1];
    end
    for (int k = 0; k < TB; k++) begin
      pw_p1[k]       = pw_src[k].r1 * pw_src[k].bs1;
      pw_p2[k]       = pw_src[k].r2 * pw_src[k].bs2;
      pw_s1[k]       = pw_src[k].bs1 * pw_src[k].bs1;
      pw_s2[k]       = pw_src[k].bs2 * pw_src[k].bs2;
      pw_item_nxt[k] = pw_src[k];
      if (pw_src[k].t[k]) begin
        pw_item_nxt[k].r1 = 25'(pw_p1[k] >> 24);
        pw_item_nxt[k].r2 = 25'(pw_p2[k] >> 24);
      end
      pw_item_nxt[k].bs1 = pw_s1[k][47:24];
      pw_item_nxt[k].bs2 = pw_s2[k][47:24];
    end
  end

  // bias correction
  item_t       pe_item;
  logic        bm_vld, bm_ovf, bm_neg;
  logic [31:0] bm_q;
  logic        bv_vld, bv_ovf;
  logic [31:0] bv_q;
  item_t       bv_item;

  assign pe_item = pw_item_r[TB-1];

  apu_div #(.NW(56), .DW(25), .QW(32), .SW(1)) u_mdiv (
    .clk(clk), .rst_n(rst_n), .in_valid(pw_vld_r[TB-1]),
    .in_num({abs32(pe_item.m), 24'b0}), .in_den(apu_pkg::COEF_ONE - pe_item.r1),
    .in_side(pe_item.m[31]),
    .out_valid(bm_vld), .out_quo(bm_q), .out_ovf(bm_ovf), .out_side(bm_neg)
  );

  apu_div #(.NW(56), .DW(25), .QW(32), .SW(IW)) u_vdiv (
    .clk(clk), .rst_n(rst_n), .in_valid(pw_vld_r[TB-1]),
    .in_num({pe_item.v, 24'b0}), .in_den(apu_pkg::COEF_ONE - pe_item.r2),
    .in_side(pe_item),
    .out_valid(bv_vld), .out_quo(bv_q), .out_ovf(bv_ovf), .out_side(bv_item)
  );

  // pick numerator and root operand
  logic  x_vld_r;
  item_t x_item_r, x_item_nxt;

  always_comb begin
    x_item_nxt = bv_item;
    if (is_adam) begin
      x_item_nxt.n = sm_sat(bm_neg, bm_q, bm_ovf);
      x_item_nxt.y = bv_ovf ? 32'hffff_ffff : bv_q;
    end else begin
      x_item_nxt.n = bv_item.g;
      x_item_nxt.y = bv_item.v;
    end
  end

  // root and step division
  logic          sq_vld;
  logic [RW-1:0] sq_root;
  item_t         sq_item;

  apu_isqrt #(.XW(XW), .SW(IW)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .in_valid(x_vld_r),
    .in_x(XW'({x_item_r.y, {FRAC_BITS{1'b0}}})), .in_side(x_item_r),
    .out_valid(sq_vld), .out_root(sq_root), .out_side(sq_item)
  );

  logic        sd_vld, sd_ovf;
  logic [31:0] sd_q;
  item_t       sd_item;

  apu_div #(.NW(32 + FRAC_BITS), .DW(RW + 1), .QW(32), .SW(IW)) u_sdiv (
    .clk(clk), .rst_n(rst_n), .in_valid(sq_vld),
    .in_num({abs32(sq_item.n), {FRAC_BITS{1'b0}}}),
    .in_den((RW+1)'(sq_root) + (RW+1)'(1)), .in_side(sq_item),
    .out_valid(sd_vld), .out_quo(sd_q), .out_ovf(sd_ovf), .out_side(sd_item)
  );

  // step, learning-rate product, output
  logic               l_vld_r;
  item_t              l_item_r, l_item_nxt;
  logic               p_vld_r;
  item_t              p_item_r;
  logic signed [56:0] p_prod_r, p_prod_nxt;
  logic               o_vld_r;
  logic signed [31:0] o_param_r, o_param_nxt;
  logic signed [31:0] o_mom_r, o_mom_nxt;
  logic [31:0]        o_vel_r, o_vel_nxt;

  always_comb begin
    l_item_nxt      = sd_item;
    l_item_nxt.step = sm_sat(sd_item.n[31], sd_q, sd_ovf);
    p_prod_nxt      = $signed({1'b0, learning_rate_r}) * l_item_r.step;
    o_param_nxt     = p_item_r.p;
    o_mom_nxt       = p_item_r.m_in;
    o_vel_nxt       = p_item_r.v_in;
    if (is_adam || is_ada) begin
      o_param_nxt = sat_s32(64'(p_item_r.p) + 64'(p_prod_r >>> 24));
      o_vel_nxt   = p_item_r.v;
    end
    if (is_adam) begin
      o_mom_nxt = p_item_r.m;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_vld_r  <= 1'b0;
      s_vld_r  <= 1'b0;
      m_vld_r  <= 1'b0;
      n_vld_r  <= 1'b0;
      v_vld_r  <= 1'b0;
      w_vld_r  <= 1'b0;
      pw_vld_r <= '0;
      x_vld_r  <= 1'b0;
      l_vld_r  <= 1'b0;
      p_vld_r  <= 1'b0;
      o_vld_r  <= 1'b0;
    end else begin
      r_vld_r  <= nd_vld;
      s_vld_r  <= r_vld_r;
      m_vld_r  <= s_vld_r;
      n_vld_r  <= m_vld_r;
      v_vld_r  <= n_vld_r;
      w_vld_r  <= v_vld_r;
      pw_vld_r <= {pw_vld_r[TB-2:0], w_vld_r};
      x_vld_r  <= bm_vld;
      l_vld_r  <= sd_vld;
      p_vld_r  <= l_vld_r;
      o_vld_r  <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    r_item_r  <= r_item_nxt;
    r_prod_r  <= r_prod_nxt;
    s_item_r  <= s_item_nxt;
    m_item_r  <= s_item_r;
    m_gg_r    <= m_gg_nxt;
    m_pm1_r   <= m_pm1_nxt;
    m_pm2_r   <= m_pm2_nxt;
    n_item_r  <= n_item_nxt;
    v_item_r  <= v_item_nxt;
    v_pv1_r   <= v_pv1_nxt;
    v_pv2_r   <= v_pv2_nxt;
    w_item_r  <= w_item_nxt;
    pw_item_r <= pw_item_nxt;
    x_item_r  <= x_item_nxt;
    l_item_r  <= l_item_nxt;
    p_item_r  <= l_item_r;
    p_prod_r  <= p_prod_nxt;
    o_param_r <= o_param_nxt;
    o_mom_r   <= o_mom_nxt;
    o_vel_r   <= o_vel_nxt;
  end

  assign out_valid        = o_vld_r;
  assign out_param_out    = o_param_r;
  assign out_momentum_out = o_mom_r;
  assign out_velocity_out = o_vel_r;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("transfer did not produce a result at the fixed latency");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without a matching input transfer");

  a_bias_align: assert property (@(posedge clk) disable iff (!rst_n)
    bm_vld == bv_vld)
    else $error("bias-correction dividers out of step");

  a_norm_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    nd_vld |-> !nd_ovf)
    else $error("normalization divide overflowed");

  a_sgd_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !is_adam && !is_ada) |-> out_param_out == $past(in_param_value, LAT))
    else $error("plain SGD changed the parameter");
`endif

endmodule

@@ rtl/core/apu_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with overflow flag and sideband.
module apu_div #(
  parameter int NW = 56,
  parameter int DW = 25,
  parameter int QW = 32,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quo,
  output logic          out_ovf,
  output logic [SW-1:0] out_side
);

  localparam int HW  = NW - QW;
  localparam int RMW = DW + 1;

  logic [QW:0]    vld_r, vld_nxt;
  logic [RMW-1:0] rem_r  [QW+1];
  logic [RMW-1:0] rem_nxt[QW+1];
  logic [QW-1:0]  quo_r  [QW+1];
  logic [QW-1:0]  quo_nxt[QW+1];
  logic [DW-1:0]  den_r  [QW+1];
  logic [DW-1:0]  den_nxt[QW+1];
  logic [QW:0]    ovf_r, ovf_nxt;
  logic [SW-1:0]  side_r  [QW+1];
  logic [SW-1:0]  side_nxt[QW+1];
  logic [RMW-1:0] sh  [QW];
  logic           ge  [QW];
  logic [HW-1:0]  hi;

  always_comb begin
    hi          = in_num[NW-1:QW];
    vld_nxt[0]  = in_valid;
    ovf_nxt[0]  = (hi >= in_den);
    rem_nxt[0]  = ovf_nxt[0] ? '0 : RMW'(hi);
    quo_nxt[0]  = in_num[QW-1:0];
    den_nxt[0]  = in_den;
    side_nxt[0] = in_side;
    for (int k = 0; k < QW; k++) begin
      sh[k]         = {rem_r[k][DW-1:0], quo_r[k][QW-1]};
      ge[k]         = (sh[k] >= {1'b0, den_r[k]});
      rem_nxt[k+1]  = ge[k] ? sh[k] - {1'b0, den_r[k]} : sh[k];
      quo_nxt[k+1]  = {quo_r[k][QW-2:0], ge[k]};
      den_nxt[k+1]  = den_r[k];
      ovf_nxt[k+1]  = ovf_r[k];
      side_nxt[k+1] = side_r[k];
      vld_nxt[k+1]  = vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    den_r  <= den_nxt;
    ovf_r  <= ovf_nxt;
    side_r <= side_nxt;
  end

  assign out_valid = vld_r[QW];
  assign out_quo   = quo_r[QW];
  assign out_ovf   = ovf_r[QW];
  assign out_side  = side_r[QW];

endmodule

@@ rtl/core/apu_isqrt.sv @@
// Pipelined floor square root, one root bit per stage, with sideband.
module apu_isqrt #(
  parameter int XW = 56,
  parameter int SW = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [XW-1:0]    in_x,
  input  logic [SW-1:0]    in_side,
  output logic             out_valid,
  output logic [XW/2-1:0]  out_root,
  output logic [SW-1:0]    out_side
);

  localparam int RW = XW / 2;

  logic [RW:0]   vld_r, vld_nxt;
  logic [RW+1:0] rem_r   [RW+1];
  logic [RW+1:0] rem_nxt [RW+1];
  logic [RW-1:0] root_r  [RW+1];
  logic [RW-1:0] root_nxt[RW+1];
  logic [XW-1:0] xs_r    [RW+1];
  logic [XW-1:0] xs_nxt  [RW+1];
  logic [SW-1:0] side_r  [RW+1];
  logic [SW-1:0] side_nxt[RW+1];
  logic [RW+1:0] sh   [RW];
  logic [RW+1:0] trial[RW];
  logic          ge   [RW];

  always_comb begin
    vld_nxt[0]  = in_valid;
    rem_nxt[0]  = '0;
    root_nxt[0] = '0;
    xs_nxt[0]   = in_x;
    side_nxt[0] = in_side;
    for (int k = 0; k < RW; k++) begin
      sh[k]          = {rem_r[k][RW-1:0], xs_r[k][XW-1:XW-2]};
      trial[k]       = {root_r[k], 2'b01};
      ge[k]          = (sh[k] >= trial[k]);
      rem_nxt[k+1]   = ge[k] ? sh[k] - trial[k] : sh[k];
      root_nxt[k+1]  = {root_r[k][RW-2:0], ge[k]};
      xs_nxt[k+1]    = {xs_r[k][XW-3:0], 2'b00};
      side_nxt[k+1]  = side_r[k];
      vld_nxt[k+1]   = vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    xs_r   <= xs_nxt;
    side_r <= side_nxt;
  end

  assign out_valid = vld_r[RW];
  assign out_root  = root_r[RW];
  assign out_side  = side_r[RW];

endmodule

@@ verif/adam_adagrad_param_update_checker.sv @@
// Checker: tracks register writes, predicts each update and compares it with the result port.
`timescale 1ns / 1ps
module adam_adagrad_param_update_checker
  import apu_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         in_mode,
  input  logic signed [31:0] in_param_value,
  input  logic signed [31:0] in_gradient,
  input  logic signed [31:0] in_momentum_in,
  input  logic [31:0]        in_velocity_in,
  input  logic [15:0]        in_sample_count,
  input  logic [15:0]        in_step_index,
  input  logic               out_valid,
  input  logic signed [31:0] out_param_out,
  input  logic signed [31:0] out_momentum_out,
  input  logic [31:0]        out_velocity_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 pending,
  output int                 fail_count
);

  localparam int     FRAC = 24;
  localparam longint Q_ONE = 64'sd16777216;
  localparam longint S_MAX = 64'sd2147483647;
  localparam longint S_MIN = -64'sd2147483648;
  localparam longint U_MAX = 64'sd4294967295;

  typedef struct packed {
    logic [31:0] param;
    logic [31:0] momentum;
    logic [31:0] velocity;
  } update_t;

  logic [1:0]  opt_sel;
  logic        norm_en;
  logic [23:0] lr, beta1, beta2, reg_u, reg_i, reg_b;

  update_t expected_updates[$];

  function automatic longint clamp_s(longint x);
    return (x > S_MAX) ? S_MAX : (x < S_MIN) ? S_MIN : x;
  endfunction

  function automatic longint clamp_u(longint x);
    return (x > U_MAX) ? U_MAX : x;
  endfunction

  function automatic longint floor_root(longint x);
    longint unsigned rem, res, bitv;
    rem = x;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(res);
  endfunction

  function automatic longint coef_power(longint b, longint e);
    longint r;
    r = Q_ONE;
    while (e != 0) begin
      if (e[0]) r = (r * b) >> COEF_BITS;
      b = (b * b) >> COEF_BITS;
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic update_t predict_update(logic [1:0] mode, logic signed [31:0] p_in,
                                             logic signed [31:0] g_in, logic signed [31:0] m_in,
                                             logic [31:0] v_in, logic [15:0] cnt,
                                             logic [15:0] stp);
    longint pv, g, m, v, rg, mag, g2, c1, c2, mh, vh, root, step, pnew, t;
    update_t r;
    pv = p_in;
    g = g_in;
    m = m_in;
    v = {32'd0, v_in};
    t = {48'd0, stp} + 1;
    pnew = pv;
    if (opt_sel == OPT_ADAM || opt_sel == OPT_ADAGRAD) begin
      if (norm_en && cnt != 0) g = g / longint'({48'd0, cnt});
      rg = (mode == MODE_USER) ? reg_u : (mode == MODE_ITEM) ? reg_i : reg_b;
      g = clamp_s(g - ((rg * pv * 2) >>> COEF_BITS));
      mag = (g < 0) ? -g : g;
      g2 = clamp_u((mag * mag) >> FRAC);
      if (opt_sel == OPT_ADAM) begin
        m = clamp_s((longint'(beta1) * m + (Q_ONE - longint'(beta1)) * g) >>> COEF_BITS);
        v = clamp_u((longint'(beta2) * v + (Q_ONE - longint'(beta2)) * g2) >> COEF_BITS);
        c1 = Q_ONE - coef_power(beta1, t);
        c2 = Q_ONE - coef_power(beta2, t);
        mh = clamp_s((m * Q_ONE) / c1);
        vh = clamp_u((v * Q_ONE) / c2);
        root = floor_root(vh * Q_ONE);
        step = clamp_s((mh * Q_ONE) / (root + 1));
      end else begin
        v = clamp_u(v + g2);
        root = floor_root(v * Q_ONE);
        step = clamp_s((g * Q_ONE) / (root + 1));
      end
      pnew = clamp_s(pv + ((longint'(lr) * step) >>> COEF_BITS));
    end
    r.param = pnew[31:0];
    r.momentum = m[31:0];
    r.velocity = v[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s got %h want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    update_t want;
    if (!rst_n) begin
      opt_sel = OPT_ADAM;
      norm_en = 1'b0;
      lr = LR_RESET;
      beta1 = B1_RESET;
      beta2 = B2_RESET;
      reg_u = '0;
      reg_i = '0;
      reg_b = '0;
      fail_count = 0;
      expected_updates.delete();
    end else begin
      if (out_valid) begin
        if (expected_updates.size() == 0) begin
          report_mismatch("unexpected transfer", out_param_out, '0);
        end else begin
          want = expected_updates.pop_front();
          if (out_param_out !== want.param)
            report_mismatch("param_out", out_param_out, want.param);
          if (out_momentum_out !== want.momentum)
            report_mismatch("momentum_out", out_momentum_out, want.momentum);
          if (out_velocity_out !== want.velocity)
            report_mismatch("velocity_out", out_velocity_out, want.velocity);
        end
      end
      if (start && !busy)
        expected_updates.insert(expected_updates.size(),
                                predict_update(in_mode, in_param_value, in_gradient,
                                               in_momentum_in, in_velocity_in,
                                               in_sample_count, in_step_index));
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_OPT:  opt_sel = pwdata[1:0];
          REG_NORM: norm_en = pwdata[0];
          REG_LR:   lr = pwdata[23:0];
          REG_B1:   beta1 = pwdata[23:0];
          REG_B2:   beta2 = pwdata[23:0];
          REG_RU:   reg_u = pwdata[23:0];
          REG_RI:   reg_i = pwdata[23:0];
          REG_RB:   reg_b = pwdata[23:0];
          default: ;
        endcase
      end
    end
    pending = expected_updates.size();
  end

endmodule

@@ verif/tb.sv @@
// Testbench top: drives updates and register writes, and gives the verdict.
`timescale 1ns / 1ps
module tb;
  import apu_pkg::*;

  localparam logic [1:0] OPT_SGD    = 2'd2;
  localparam logic [1:0] OPT_SPARE  = 2'd3;
  localparam logic [1:0] MODE_BIAS  = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int LATENCY = 155;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 56;

  logic clk = 1'b0;
  logic rst_n;
  logic start, busy;
  logic [1:0] in_mode;
  logic signed [31:0] in_param_value, in_gradient, in_momentum_in;
  logic [31:0] in_velocity_in;
  logic [15:0] in_sample_count, in_step_index;
  logic out_valid;
  logic signed [31:0] out_param_out, out_momentum_out;
  logic [31:0] out_velocity_out;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;
  int pending, fail_count, idle_pct, quiet_cycles;

  always #4 clk = ~clk;

  adam_adagrad_param_update dut (.*);

  adam_adagrad_param_update_checker checker_i (.*);

  always @(posedge clk) begin
    if (start && !busy || out_valid || psel && penable)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_update(logic [1:0] mode, logic [31:0] p, logic [31:0] g,
                             logic [31:0] m, logic [31:0] v, logic [15:0] cnt,
                             logic [15:0] stp);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= mode;
    in_param_value <= p;
    in_gradient <= g;
    in_momentum_in <= m;
    in_velocity_in <= v;
    in_sample_count <= cnt;
    in_step_index <= stp;
    do @(posedge clk); while (busy);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(4))
      0: return $urandom();
      1: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      3: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom_range(1) ? 32'h0 : 32'hffff_ffff;
    endcase
  endfunction

  function automatic logic [23:0] pick_coef(int phase, int top_phase, int zero_phase);
    if (phase == top_phase) return 24'hff_ffff;
    if (phase == zero_phase) return 24'h0;
    return $urandom_range(1) ? 24'($urandom()) : 24'($urandom_range(24'hff_ffff, 24'he0_0000));
  endfunction

  task automatic drain();
    start <= 1'b0;
    wait (pending == 0);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  initial begin
    logic [1:0] opt_plan[PHASES] = '{OPT_ADAM, OPT_ADAGRAD, OPT_ADAM, OPT_SGD,
                                     OPT_ADAGRAD, OPT_ADAM, OPT_SPARE, OPT_ADAGRAD};
    int n;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_mode <= MODE_USER;
    in_param_value <= '0;
    in_gradient <= '0;
    in_momentum_in <= '0;
    in_velocity_in <= '0;
    in_sample_count <= '0;
    in_step_index <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    idle_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_update(MODE_USER, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 0, 0);
    send_update(MODE_ITEM, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 1, 16'hffff);
    send_update(MODE_BIAS, 32'h0100_0000, 32'hff00_0000, 32'h0, 32'h0100_0000, 16'hffff, 1);
    send_update(MODE_SPARE, 32'h0, 32'h0, 32'h0, 32'h0, 0, 0);
    drain();
    write_reg(REG_NORM, 32'h1);
    write_reg(REG_RU, 32'hff_ffff);
    write_reg(REG_RI, 32'h80_0000);
    write_reg(REG_RB, 32'h10_0000);
    send_update(MODE_USER, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h0, 16'hffff, 0);
    send_update(MODE_ITEM, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'hffff_ffff, 3, 7);
    send_update(MODE_BIAS, 32'h8000_0000, 32'h0, 32'h7fff_ffff, 32'h0, 0, 16'hffff);
    send_update(MODE_SPARE, 32'h7fff_ffff, 32'h0123_4567, 32'h8000_0000, 32'h1, 2, 2);
    send_update(MODE_USER, 32'h0100_0000, 32'h8000_0000, 32'h0, 32'h0, 16'hffff, 3);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      write_reg(REG_OPT, {$urandom() & 32'hffff_fffc} | opt_plan[ph]);
      write_reg(REG_NORM, {$urandom() & 32'hffff_fffe} | ph[0]);
      write_reg(REG_LR, {8'($urandom()), pick_coef(ph, 2, 3)});
      write_reg(REG_B1, {8'($urandom()), pick_coef(ph, 4, 5)});
      write_reg(REG_B2, {8'($urandom()), pick_coef(ph, 5, 4)});
      write_reg(REG_RU, {8'($urandom()), ph == 6 ? 24'hff_ffff : 24'($urandom_range(24'h1_0000))});
      write_reg(REG_RI, {8'($urandom()), ph == 1 ? 24'h0 : 24'($urandom())});
      write_reg(REG_RB, {8'($urandom()), ph == 7 ? 24'hff_ffff : 24'($urandom_range(24'h8_0000))});
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        n = ph * PHASE_ITEMS + k;
        idle_pct = (n < 150) ? 26 : (n < 300) ? 59 : 0;
        send_update(2'($urandom()), pick_value(), pick_value(), pick_value(), pick_value(),
                    $urandom_range(3) == 0 ? 16'($urandom()) : 16'($urandom_range(3)),
                    $urandom_range(3) == 0 ? 16'($urandom()) : 16'($urandom_range(20)));
        if (k == PHASE_ITEMS / 2 && ph == 2) begin
          start <= 1'b0;
          @(posedge clk);
          wait (pending == 0);
          @(posedge clk);
        end
      end
    end
    drain();
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/apu_pkg.sv
rtl/core/apu_div.sv
rtl/core/apu_isqrt.sv
rtl/core/adam_adagrad_param_update.sv
verif/adam_adagrad_param_update_checker.sv
verif/tb.sv
